// File: rtl/hpd_pkg.sv
// Shared types, mode codes, register indexes and constants of the hinge posture detector.
package hpd_pkg;

  // Posture codes.
  localparam logic [2:0] MODE_CLOSING = 3'd0;
  localparam logic [2:0] MODE_LAPTOP  = 3'd1;
  localparam logic [2:0] MODE_FLAT    = 3'd2;
  localparam logic [2:0] MODE_TENT    = 3'd3;
  localparam logic [2:0] MODE_TABLET  = 3'd4;
  localparam logic [2:0] MODE_INDET   = 3'd5;
  localparam int unsigned NUM_MODES   = 6;

  // Configuration register indexes.
  localparam logic [2:0] REG_CLOSING_LIMIT      = 3'd0;
  localparam logic [2:0] REG_LAPTOP_LIMIT       = 3'd1;
  localparam logic [2:0] REG_FLAT_LIMIT         = 3'd2;
  localparam logic [2:0] REG_TENT_LIMIT         = 3'd3;
  localparam logic [2:0] REG_BAND_HYSTERESIS    = 3'd4;
  localparam logic [2:0] REG_CLOSING_HYSTERESIS = 3'd5;
  localparam logic [2:0] REG_CONFIRM_SAMPLES    = 3'd6;
  localparam logic [2:0] REG_GRAVITY_FLOOR      = 3'd7;

  // Register reset values.
  localparam logic [11:0] RST_CLOSING_LIMIT      = 12'd450;
  localparam logic [11:0] RST_LAPTOP_LIMIT       = 12'd1600;
  localparam logic [11:0] RST_FLAT_LIMIT         = 12'd2400;
  localparam logic [11:0] RST_TENT_LIMIT         = 12'd3450;
  localparam logic [9:0]  RST_BAND_HYSTERESIS    = 10'd60;
  localparam logic [9:0]  RST_CLOSING_HYSTERESIS = 10'd30;
  localparam logic [3:0]  RST_CONFIRM_SAMPLES    = 4'd3;
  localparam logic [15:0] RST_GRAVITY_FLOOR      = 16'd750;

  // Gravity confidence limits, hundredths of m/s^2.
  localparam logic [15:0] MAG_CEIL     = 16'd1300;
  localparam logic [15:0] TENT_FLOOR   = 16'd550;
  localparam logic [15:0] TOL_CLOSING  = 16'd1200;
  localparam logic [15:0] TOL_LAPTOP   = 16'd1200;
  localparam logic [15:0] TOL_FLAT     = 16'd1800;
  localparam logic [15:0] TOL_TENT     = 16'd2000;
  localparam logic [15:0] TOL_TABLET   = 16'd1500;
  localparam logic [15:0] TOL_INDET    = 16'd2000;

  localparam logic [3:0] AGREE_MAX = 4'd15;

  // Queue between front and back.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic signed [12:0] hinge_angle;
    logic [15:0]        base_magnitude;
    logic [15:0]        lid_magnitude;
    logic [15:0]        horizontal_accel;
  } in_item_t;

  typedef struct packed {
    logic [2:0] posture;
    logic       posture_changed;
  } out_item_t;

  typedef struct packed {
    logic [11:0] closing_limit;
    logic [11:0] laptop_limit;
    logic [11:0] flat_limit;
    logic [11:0] tent_limit;
    logic [9:0]  band_hysteresis;
    logic [9:0]  closing_hysteresis;
    logic [3:0]  confirm_samples;
    logic [15:0] gravity_floor;
  } cfg_t;

  // Everything about a sample that does not depend on the committed state.
  typedef struct packed {
    logic                 angle_neg;  // invalid angle
    logic [2:0]           angle_bin;  // band of the angle
    logic [NUM_MODES-1:0] grav_ok;    // gravity check passes, one bit per mode
    logic [3:0]           hold_up;    // rising past limit k is still inside hysteresis
    logic [3:0]           hold_dn;    // falling past limit k is still inside hysteresis
  } class_t;

endpackage

// File: rtl/hpd_front.sv
// Front classifier: bins the angle, runs all gravity checks and hysteresis compares.
module hpd_front (
  input  hpd_pkg::cfg_t     cfg,
  input  hpd_pkg::in_item_t item,
  output hpd_pkg::class_t   cls
);

  logic signed [14:0] angle;
  logic signed [14:0] lim [4];
  logic signed [14:0] hy  [4];
  logic               mag_gen;
  logic               mag_tent;

  assign angle  = 15'(item.hinge_angle);
  assign lim[0] = $signed({3'b000, cfg.closing_limit});
  assign lim[1] = $signed({3'b000, cfg.laptop_limit});
  assign lim[2] = $signed({3'b000, cfg.flat_limit});
  assign lim[3] = $signed({3'b000, cfg.tent_limit});
  // The closing/laptop boundary has its own hysteresis.
  assign hy[0]  = $signed({5'b00000, cfg.closing_hysteresis});
  assign hy[1]  = $signed({5'b00000, cfg.band_hysteresis});
  assign hy[2]  = $signed({5'b00000, cfg.band_hysteresis});
  assign hy[3]  = $signed({5'b00000, cfg.band_hysteresis});

  assign mag_gen  = (item.base_magnitude >= cfg.gravity_floor) &&
                    (item.base_magnitude <= hpd_pkg::MAG_CEIL) &&
                    (item.lid_magnitude >= cfg.gravity_floor) &&
                    (item.lid_magnitude <= hpd_pkg::MAG_CEIL);
  assign mag_tent = (item.base_magnitude >= hpd_pkg::TENT_FLOOR) &&
                    (item.base_magnitude <= hpd_pkg::MAG_CEIL) &&
                    (item.lid_magnitude >= hpd_pkg::TENT_FLOOR) &&
                    (item.lid_magnitude <= hpd_pkg::MAG_CEIL);

  always_comb begin
    cls.angle_neg = item.hinge_angle < 0;
    // Bands are tested in ascending register order, as written.
    if (angle < lim[0]) begin
      cls.angle_bin = hpd_pkg::MODE_CLOSING;
    end else if (angle < lim[1]) begin
      cls.angle_bin = hpd_pkg::MODE_LAPTOP;
    end else if (angle < lim[2]) begin
      cls.angle_bin = hpd_pkg::MODE_FLAT;
    end else if (angle < lim[3]) begin
      cls.angle_bin = hpd_pkg::MODE_TENT;
    end else begin
      cls.angle_bin = hpd_pkg::MODE_TABLET;
    end

    cls.grav_ok[hpd_pkg::MODE_CLOSING] = mag_gen && (item.horizontal_accel < hpd_pkg::TOL_CLOSING);
    cls.grav_ok[hpd_pkg::MODE_LAPTOP]  = mag_gen && (item.horizontal_accel < hpd_pkg::TOL_LAPTOP);
    cls.grav_ok[hpd_pkg::MODE_FLAT]    = mag_gen && (item.horizontal_accel < hpd_pkg::TOL_FLAT);
    cls.grav_ok[hpd_pkg::MODE_TENT]    = mag_tent && (item.horizontal_accel < hpd_pkg::TOL_TENT);
    cls.grav_ok[hpd_pkg::MODE_TABLET]  = mag_gen && (item.horizontal_accel < hpd_pkg::TOL_TABLET);
    cls.grav_ok[hpd_pkg::MODE_INDET]   = mag_gen && (item.horizontal_accel < hpd_pkg::TOL_INDET);

    for (int k = 0; k < 4; k++) begin
      cls.hold_up[k] = angle < (lim[k] + hy[k]);
      cls.hold_dn[k] = angle > (lim[k] - hy[k]);
    end
  end

endmodule

// File: rtl/hpd_queue.sv
// Short queue of classified samples between the front and the back.
module hpd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  hpd_pkg::class_t   push_data,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output hpd_pkg::class_t   pop_data
);

  hpd_pkg::class_t                 mem [hpd_pkg::QDEPTH];
  logic [hpd_pkg::QPTR_W-1:0]      wr_ptr;
  logic [hpd_pkg::QPTR_W-1:0]      rd_ptr;
  logic [hpd_pkg::QCNT_W-1:0]      count;

  assign full      = count == hpd_pkg::QCNT_W'(hpd_pkg::QDEPTH);
  assign not_empty = count != '0;
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == hpd_pkg::QPTR_W'(hpd_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == hpd_pkg::QPTR_W'(hpd_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/hpd_back.sv
// Back end: picks the candidate mode against the committed one and runs the commit filter.
module hpd_back (
  input  logic                clk,
  input  logic                rst,
  input  logic [3:0]          confirm_samples,
  input  logic                take,
  input  hpd_pkg::class_t     cls,
  output hpd_pkg::out_item_t  result
);

  logic [2:0] committed;
  logic [2:0] pending_mode;
  logic       pending_valid;
  logic [3:0] agree_count;

  logic [2:0] committed_next;
  logic [2:0] pending_mode_next;
  logic       pending_valid_next;
  logic [3:0] agree_count_next;
  logic       changed;
  logic [2:0] cand;
  logic [2:0] ang_mode;
  logic       jump_ok;
  logic       hold;
  logic [3:0] agree_inc;

  always_comb begin
    // Jumps between non-adjacent modes are refused, laptop and tent excepted; any jump out of indeterminate is allowed.
    jump_ok = (committed == hpd_pkg::MODE_INDET) || (committed == cls.angle_bin) ||
              (committed + 3'd1 == cls.angle_bin) || (cls.angle_bin + 3'd1 == committed) ||
              ((committed == hpd_pkg::MODE_LAPTOP) && (cls.angle_bin == hpd_pkg::MODE_TENT)) ||
              ((committed == hpd_pkg::MODE_TENT) && (cls.angle_bin == hpd_pkg::MODE_LAPTOP));

    hold = 1'b0;
    case ({committed, cls.angle_bin})
      {hpd_pkg::MODE_CLOSING, hpd_pkg::MODE_LAPTOP}:  hold = cls.hold_up[0];
      {hpd_pkg::MODE_LAPTOP,  hpd_pkg::MODE_FLAT}:    hold = cls.hold_up[1];
      {hpd_pkg::MODE_FLAT,    hpd_pkg::MODE_TENT}:    hold = cls.hold_up[2];
      {hpd_pkg::MODE_TENT,    hpd_pkg::MODE_TABLET}:  hold = cls.hold_up[3];
      {hpd_pkg::MODE_LAPTOP,  hpd_pkg::MODE_CLOSING}: hold = cls.hold_dn[0];
      {hpd_pkg::MODE_FLAT,    hpd_pkg::MODE_LAPTOP}:  hold = cls.hold_dn[1];
      {hpd_pkg::MODE_TENT,    hpd_pkg::MODE_FLAT}:    hold = cls.hold_dn[2];
      {hpd_pkg::MODE_TABLET,  hpd_pkg::MODE_TENT}:    hold = cls.hold_dn[3];
      default:                                        hold = 1'b0;
    endcase

    if (cls.angle_neg) begin
      ang_mode = hpd_pkg::MODE_LAPTOP;
    end else if (!jump_ok || hold) begin
      ang_mode = committed;
    end else begin
      ang_mode = cls.angle_bin;
    end

    // The committed mode never exceeds the indeterminate code.
    if (cls.grav_ok[committed] || cls.grav_ok[cls.angle_bin]) begin
      cand = ang_mode;
    end else if (!cls.grav_ok[hpd_pkg::MODE_TENT]) begin
      cand = hpd_pkg::MODE_INDET;
    end else begin
      cand = committed;
    end

    agree_inc          = (agree_count == hpd_pkg::AGREE_MAX) ? agree_count : agree_count + 4'd1;
    committed_next     = committed;
    pending_mode_next  = pending_mode;
    pending_valid_next = pending_valid;
    agree_count_next   = agree_count;
    changed            = 1'b0;
    if (cand == committed) begin
      agree_count_next   = '0;
      pending_valid_next = 1'b0;
    end else if (!pending_valid || (pending_mode != cand)) begin
      pending_mode_next  = cand;
      pending_valid_next = 1'b1;
      agree_count_next   = 4'd1;
    end else if (agree_inc >= confirm_samples) begin
      committed_next     = cand;
      pending_valid_next = 1'b0;
      agree_count_next   = '0;
      changed            = 1'b1;
    end else begin
      agree_count_next   = agree_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      committed     <= hpd_pkg::MODE_LAPTOP;
      pending_mode  <= hpd_pkg::MODE_CLOSING;
      pending_valid <= 1'b0;
      agree_count   <= '0;
    end else if (take) begin
      committed     <= committed_next;
      pending_mode  <= pending_mode_next;
      pending_valid <= pending_valid_next;
      agree_count   <= agree_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.posture         <= committed_next;
      result.posture_changed <= changed;
    end
  end

endmodule

// File: rtl/hinge_posture_detector_core.sv
// Top level of the hinge posture detector: register file, front, queue and back.
// A request accepted into the queue is registered there and then in the output register
// before its result shows, when nothing is stalled. Throughput: one request per cycle
// while the output is not stalled; the back end's state update sets it.
// Reset (synchronous, rst high) restores register defaults, commits laptop, clears the
// pending candidate, empties the queue and output register and holds off new requests.
module hinge_posture_detector_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  hpd_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output hpd_pkg::out_item_t  out_item
);

  hpd_pkg::cfg_t   cfg;
  hpd_pkg::class_t front_cls;
  hpd_pkg::class_t back_cls;
  logic            q_full;
  logic            q_not_empty;
  logic            push;
  logic            take;

  // Configuration registers. Writes must arrive only while the block is idle; the block
  // itself does not enforce this. The front and the back read them without any shadowing.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.closing_limit      <= hpd_pkg::RST_CLOSING_LIMIT;
      cfg.laptop_limit       <= hpd_pkg::RST_LAPTOP_LIMIT;
      cfg.flat_limit         <= hpd_pkg::RST_FLAT_LIMIT;
      cfg.tent_limit         <= hpd_pkg::RST_TENT_LIMIT;
      cfg.band_hysteresis    <= hpd_pkg::RST_BAND_HYSTERESIS;
      cfg.closing_hysteresis <= hpd_pkg::RST_CLOSING_HYSTERESIS;
      cfg.confirm_samples    <= hpd_pkg::RST_CONFIRM_SAMPLES;
      cfg.gravity_floor      <= hpd_pkg::RST_GRAVITY_FLOOR;
    end else if (cfg_write) begin
      unique case (cfg_index)
        hpd_pkg::REG_CLOSING_LIMIT:      cfg.closing_limit      <= cfg_data[11:0];
        hpd_pkg::REG_LAPTOP_LIMIT:       cfg.laptop_limit       <= cfg_data[11:0];
        hpd_pkg::REG_FLAT_LIMIT:         cfg.flat_limit         <= cfg_data[11:0];
        hpd_pkg::REG_TENT_LIMIT:         cfg.tent_limit         <= cfg_data[11:0];
        hpd_pkg::REG_BAND_HYSTERESIS:    cfg.band_hysteresis    <= cfg_data[9:0];
        hpd_pkg::REG_CLOSING_HYSTERESIS: cfg.closing_hysteresis <= cfg_data[9:0];
        hpd_pkg::REG_CONFIRM_SAMPLES:    cfg.confirm_samples    <= cfg_data[3:0];
        hpd_pkg::REG_GRAVITY_FLOOR:      cfg.gravity_floor      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The front stalls while reset is held and when the queue is full; it never looks
  // at the output side.
  assign in_stall = rst || q_full;
  assign push     = in_valid && !in_stall;

  hpd_front u_front (
    .cfg  (cfg),
    .item (in_item),
    .cls  (front_cls)
  );

  hpd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_cls),
    .full      (q_full),
    .pop       (take),
    .not_empty (q_not_empty),
    .pop_data  (back_cls)
  );

  // The back takes the next queued sample whenever the output register is free
  // or is being emptied in this same cycle.
  assign take = q_not_empty && (!out_valid || !out_stall);

  hpd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .confirm_samples (cfg.confirm_samples),
    .take            (take),
    .cls             (back_cls),
    .result          (out_item)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule
